### hw/rtl/tsc_pkg.sv
`timescale 1ns / 1ps

package tsc_pkg;

  // Number of series terms after the first one
  localparam int TERMS = 10;

  // Fraction bits of the internal radian, square and term values
  localparam int FRAC = 28;

  localparam int ANG_W  = 17;
  localparam int AMAG_W = 16;
  localparam logic signed [ANG_W-1:0] ANGLE_MAX = 17'sd46080;
  localparam logic signed [ANG_W-1:0] ANGLE_MIN = -17'sd46080;

  // pi / 180 scaled by 2^40
  localparam int RAD_W = 35;
  localparam logic [RAD_W-1:0] RAD_PER_DEG = 35'd19190098069;
  localparam int RAD_SHIFT = 20;
  localparam int PROD_W = AMAG_W + RAD_W;

  localparam int X_W  = 30;
  localparam int SQ_W = 2 * X_W;
  localparam int X2_W = 32;
  localparam int TERM_W = 31;

  // Term product, its scaled-down numerator and the reciprocal split
  localparam int P_W  = TERM_W + X2_W;
  localparam int N_W  = P_W + 1 - FRAC;
  localparam int NL_W = N_W / 2;
  localparam int NH_W = N_W - NL_W;
  localparam int S_W  = 2 * N_W;

  localparam int DMAX  = 2 * TERMS * (2 * TERMS + 1);
  localparam int D_W   = $clog2(DMAX + 1);
  localparam int RES_W = D_W + 1;

  localparam int SUM_W = 34;
  localparam int VAL_W = 32;

  localparam logic [PROD_W:0] X_HALF =
      {{(PROD_W - RAD_SHIFT + 1){1'b0}}, 1'b1, {(RAD_SHIFT - 1){1'b0}}};
  localparam logic [SQ_W:0] SQ_HALF =
      {{(SQ_W - FRAC + 1){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
  localparam logic [TERM_W-1:0] ONE_Q28 = 31'd268435456;
  localparam logic signed [SUM_W+1:0] ONE_Q30 = 36'sd1073741824;
  localparam logic signed [SUM_W+1:0] NEG_ONE_Q30 = -36'sd1073741824;

  localparam logic [1:0] SKID_DEPTH = 2'd2;

  // One item in flight between series stages: current term as sign and
  // magnitude, plus the sum of all earlier terms
  typedef struct packed {
    logic                    valid;
    logic                    cos;
    logic                    neg;
    logic [TERM_W-1:0]       mag;
    logic signed [SUM_W-1:0] sum;
    logic [X2_W-1:0]         x2;
  } term_t;

  // Divisor of term k: 2k(2k+1) for sine, 2k(2k-1) for cosine
  function automatic logic [D_W-1:0] pair_prod(input int k, input logic cos);
    int p;
    p = cos ? 2 * k * (2 * k - 1) : 2 * k * (2 * k + 1);
    return p[D_W-1:0];
  endfunction

endpackage

### hw/rtl/tsc_angle.sv
`timescale 1ns / 1ps

module tsc_angle (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              req_valid,
  input  logic                              req_type,
  input  logic signed [tsc_pkg::ANG_W-1:0]  angle_deg,
  output tsc_pkg::term_t                    dout
);

  logic signed [tsc_pkg::ANG_W-1:0] a_c;
  logic [tsc_pkg::ANG_W-1:0]        a_abs;
  logic [tsc_pkg::PROD_W:0]         xr;
  logic [tsc_pkg::SQ_W:0]           x2r;

  logic v1, v2, v3, v4;
  logic cos1, cos2, cos3, cos4;
  logic neg1, neg2, neg3, neg4;
  logic [tsc_pkg::AMAG_W-1:0] mag1;
  logic [tsc_pkg::PROD_W-1:0] prod2;
  logic [tsc_pkg::X_W-1:0]    xm3, xm4;
  logic [tsc_pkg::SQ_W-1:0]   sq4;

  always_comb begin
    if (angle_deg > tsc_pkg::ANGLE_MAX) begin
      a_c = tsc_pkg::ANGLE_MAX;
    end else if (angle_deg < tsc_pkg::ANGLE_MIN) begin
      a_c = tsc_pkg::ANGLE_MIN;
    end else begin
      a_c = angle_deg;
    end
    a_abs = a_c[tsc_pkg::ANG_W-1] ? -a_c : a_c;
    xr    = {1'b0, prod2} + tsc_pkg::X_HALF;
    x2r   = {1'b0, sq4} + tsc_pkg::SQ_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      dout.valid <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      dout.valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos1  <= req_type;
      neg1  <= angle_deg[tsc_pkg::ANG_W-1];
      mag1  <= a_abs[tsc_pkg::AMAG_W-1:0];
      cos2  <= cos1;
      neg2  <= neg1;
      prod2 <= mag1 * tsc_pkg::RAD_PER_DEG;
      cos3  <= cos2;
      neg3  <= neg2;
      xm3   <= xr[tsc_pkg::RAD_SHIFT+tsc_pkg::X_W-1:tsc_pkg::RAD_SHIFT];
      cos4  <= cos3;
      neg4  <= neg3;
      xm4   <= xm3;
      sq4   <= xm3 * xm3;
      // First term: one for cosine, x for sine
      dout.cos <= cos4;
      dout.neg <= cos4 ? 1'b0 : neg4;
      dout.mag <= cos4 ? tsc_pkg::ONE_Q28 : {1'b0, xm4};
      dout.sum <= '0;
      dout.x2  <= x2r[tsc_pkg::FRAC+tsc_pkg::X2_W-1:tsc_pkg::FRAC];
    end
  end

endmodule

### hw/rtl/tsc_term.sv
`timescale 1ns / 1ps

module tsc_term (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  tsc_pkg::term_t            din,
  input  logic [tsc_pkg::D_W-1:0]   div_sin,
  input  logic [tsc_pkg::D_W-1:0]   div_cos,
  input  logic [tsc_pkg::N_W-1:0]   rcp_sin,
  input  logic [tsc_pkg::N_W-1:0]   rcp_cos,
  output tsc_pkg::term_t            dout
);

  logic signed [tsc_pkg::SUM_W-1:0] tpos, tsv;
  logic [tsc_pkg::D_W-1:0]          d2, d5;
  logic [tsc_pkg::N_W-1:0]          rcp3;
  logic [tsc_pkg::P_W:0]            nsum;
  logic [tsc_pkg::S_W-1:0]          s4;
  logic [tsc_pkg::RES_W+tsc_pkg::D_W-1:0] qd;
  logic [tsc_pkg::RES_W-1:0]        r5;
  logic                             bump;

  logic v1, v2, v3, v4;
  logic cos1, cos2, cos3, cos4;
  logic neg1, neg2, neg3, neg4;
  logic signed [tsc_pkg::SUM_W-1:0] sum1, sum2, sum3, sum4;
  logic [tsc_pkg::X2_W-1:0]         x2_1, x2_2, x2_3, x2_4;
  logic [tsc_pkg::P_W-1:0]          p1;
  logic [tsc_pkg::N_W-1:0]          n2;
  logic [tsc_pkg::NL_W+tsc_pkg::N_W-1:0] pp_lo3;
  logic [tsc_pkg::NH_W+tsc_pkg::N_W-1:0] pp_hi3;
  logic [tsc_pkg::RES_W-1:0]        n3, n4;
  logic [tsc_pkg::TERM_W-1:0]       q4;

  always_comb begin
    tpos = $signed({{(tsc_pkg::SUM_W-tsc_pkg::TERM_W){1'b0}}, din.mag});
    tsv  = din.neg ? -tpos : tpos;
    d2   = cos1 ? div_cos : div_sin;
    rcp3 = cos2 ? rcp_cos : rcp_sin;
    d5   = cos4 ? div_cos : div_sin;
    // Add half the divisor, then drop the fraction bits of the divisor scale
    nsum = {1'b0, p1} + {{(tsc_pkg::P_W-tsc_pkg::D_W-tsc_pkg::FRAC+2){1'b0}}, d2,
                         {(tsc_pkg::FRAC-1){1'b0}}};
    s4   = {pp_hi3, {tsc_pkg::NL_W{1'b0}}}
         + {{(tsc_pkg::S_W-tsc_pkg::NL_W-tsc_pkg::N_W){1'b0}}, pp_lo3};
    // Estimate is low by at most one: remainder stays below twice the divisor
    qd   = q4[tsc_pkg::RES_W-1:0] * d5;
    r5   = n4 - qd[tsc_pkg::RES_W-1:0];
    bump = (r5 >= {1'b0, d5});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      dout.valid <= 1'b0;
    end else if (en) begin
      v1 <= din.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      dout.valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos1 <= din.cos;
      neg1 <= ~din.neg;
      x2_1 <= din.x2;
      sum1 <= din.sum + tsv;
      p1   <= din.mag * din.x2;

      cos2 <= cos1;
      neg2 <= neg1;
      x2_2 <= x2_1;
      sum2 <= sum1;
      n2   <= nsum[tsc_pkg::P_W:tsc_pkg::FRAC];

      cos3   <= cos2;
      neg3   <= neg2;
      x2_3   <= x2_2;
      sum3   <= sum2;
      n3     <= n2[tsc_pkg::RES_W-1:0];
      pp_lo3 <= n2[tsc_pkg::NL_W-1:0] * rcp3;
      pp_hi3 <= n2[tsc_pkg::N_W-1:tsc_pkg::NL_W] * rcp3;

      cos4 <= cos3;
      neg4 <= neg3;
      x2_4 <= x2_3;
      sum4 <= sum3;
      n4   <= n3;
      q4   <= s4[tsc_pkg::N_W+tsc_pkg::TERM_W-1:tsc_pkg::N_W];

      dout.cos <= cos4;
      dout.neg <= neg4;
      dout.x2  <= x2_4;
      dout.sum <= sum4;
      dout.mag <= q4 + {{(tsc_pkg::TERM_W-1){1'b0}}, bump};
    end
  end

endmodule

### hw/rtl/tsc_out.sv
`timescale 1ns / 1ps

module tsc_out (
  input  logic                              clk,
  input  logic                              rst,
  input  tsc_pkg::term_t                    din,
  input  logic                              rsp_ready,
  output logic                              rsp_valid,
  output logic signed [tsc_pkg::VAL_W-1:0]  value,
  output logic                              en
);

  logic signed [tsc_pkg::SUM_W-1:0] tpos, tsv;
  logic signed [tsc_pkg::SUM_W+1:0] v4, sat;
  logic signed [tsc_pkg::VAL_W-1:0] res;
  logic                             push, pop;

  logic                             fv;
  logic signed [tsc_pkg::SUM_W-1:0] total;
  logic [1:0]                       count;
  logic signed [tsc_pkg::VAL_W-1:0] ent0, ent1;

  always_comb begin
    tpos = $signed({{(tsc_pkg::SUM_W-tsc_pkg::TERM_W){1'b0}}, din.mag});
    tsv  = din.neg ? -tpos : tpos;
    v4   = {total, 2'b00};
    if (v4 > tsc_pkg::ONE_Q30) begin
      sat = tsc_pkg::ONE_Q30;
    end else if (v4 < tsc_pkg::NEG_ONE_Q30) begin
      sat = tsc_pkg::NEG_ONE_Q30;
    end else begin
      sat = v4;
    end
    res  = sat[tsc_pkg::VAL_W-1:0];
    // Hold the whole pipeline only once both skid entries are taken
    en        = (count != tsc_pkg::SKID_DEPTH);
    rsp_valid = (count != 2'd0);
    value     = ent0;
    push      = en && fv;
    pop       = rsp_valid && rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (en) begin
        fv <= din.valid;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total <= din.sum + tsv;
    end
    if (push && !pop) begin
      if (count == 2'd0) begin
        ent0 <= res;
      end else begin
        ent1 <= res;
      end
    end else if (pop && !push) begin
      ent0 <= ent1;
    end else if (pop && push) begin
      if (count == 2'd1) begin
        ent0 <= res;
      end else begin
        ent0 <= ent1;
        ent1 <= res;
      end
    end
  end

endmodule

### hw/rtl/taylor_sine_cosine.sv
`timescale 1ns / 1ps

// Sine or cosine of an angle in degrees (signed, 8 fraction bits, clamped to
// +/-180) by a Taylor series of TERMS terms after the first, returned as
// signed Q2.30 saturated to +/-1. The block takes one request per cycle while
// req_ready is high and returns results in request order. Five stages convert
// the angle and square it, each series term takes five stages (term times x
// squared, rounding, two reciprocal partial products, their sum, quotient
// correction), then one stage for the final add and saturation before a
// two-entry output buffer. The pipeline holds only when that buffer is full,
// so requests keep flowing while no more than one result waits unread.
module taylor_sine_cosine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic                              req_type,
  input  logic signed [tsc_pkg::ANG_W-1:0]  angle_deg,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic signed [tsc_pkg::VAL_W-1:0]  value
);

  logic           en;
  tsc_pkg::term_t chain [tsc_pkg::TERMS+1];

  assign req_ready = en;

  tsc_angle u_angle (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .req_valid (req_valid),
    .req_type  (req_type),
    .angle_deg (angle_deg),
    .dout      (chain[0])
  );

  for (genvar i = 1; i <= tsc_pkg::TERMS; i++) begin : g_term
    localparam logic [tsc_pkg::D_W-1:0] DS = tsc_pkg::pair_prod(i, 1'b0);
    localparam logic [tsc_pkg::D_W-1:0] DC = tsc_pkg::pair_prod(i, 1'b1);
    // Reciprocals rounded down, scaled by 2^N_W
    localparam logic [tsc_pkg::S_W-1:0] RS = ({{(tsc_pkg::S_W-1){1'b0}}, 1'b1}
                                              << tsc_pkg::N_W) / DS;
    localparam logic [tsc_pkg::S_W-1:0] RC = ({{(tsc_pkg::S_W-1){1'b0}}, 1'b1}
                                              << tsc_pkg::N_W) / DC;

    tsc_term u_term (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .din     (chain[i-1]),
      .div_sin (DS),
      .div_cos (DC),
      .rcp_sin (RS[tsc_pkg::N_W-1:0]),
      .rcp_cos (RC[tsc_pkg::N_W-1:0]),
      .dout    (chain[i])
    );
  end

  tsc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .din       (chain[tsc_pkg::TERMS]),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .value     (value),
    .en        (en)
  );

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid)
    else $error("request side held while no result waits");

  a_stall_holds_last_term: assert property (@(posedge clk) disable iff (rst)
    (!req_ready && chain[tsc_pkg::TERMS].valid) |=>
      (chain[tsc_pkg::TERMS].valid && $stable(chain[tsc_pkg::TERMS].mag)))
    else $error("last series stage changed while held");

  a_value_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((value <= 32'sd1073741824) && (value >= -32'sd1073741824)))
    else $error("result outside plus or minus one");
`endif

endmodule
